@@ hdl/square_to_ellipse_pixel_remap_core_macros.svh @@
// Assertion macros used by the checker file of the remap core.
`ifndef SQUARE_TO_ELLIPSE_PIXEL_REMAP_CORE_MACROS_SVH
`define SQUARE_TO_ELLIPSE_PIXEL_REMAP_CORE_MACROS_SVH

// Property checked while reset is low.
`define SER_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("remap core assertion failed");

// Property checked at every edge, reset included.
`define SER_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("remap core assertion failed");

`endif

@@ hdl/ser_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ser_pkg;

   localparam int DIM_W     = 13;
   localparam int PIX_W     = 12;
   localparam int MAX_DIM   = 4096;
   localparam int FRAC_BITS = 16;
   localparam int Q_W       = FRAC_BITS + 1;
   localparam int ROOT_W    = FRAC_BITS + 1;
   localparam int OFF_W     = DIM_W + 2;
   localparam int PROD_W    = 2 * DIM_W;
   localparam int RAD_W     = 2 * FRAC_BITS + 4;
   localparam int MUL_W     = ROOT_W + 1 + OFF_W;
   localparam int SUM_W     = MUL_W + 1;
   localparam int COORD_W   = SUM_W - FRAC_BITS - 1;
   // Three front stages, divider, square, root, multiply, add, output.
   localparam int LATENCY   = 7 + Q_W + ROOT_W;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] src_x;
      logic [PIX_W-1:0] src_y;
      logic             use_fill;
   } rsp_type;

   // Doubled offsets from the centre, carried alongside the ratio.
   typedef struct packed {
      logic signed [OFF_W-1:0] dx2;
      logic signed [OFF_W-1:0] dy2;
   } side_type;

endpackage

`default_nettype wire

@@ hdl/ser_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ser_div_pipe (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [ser_pkg::PROD_W-1:0] in_mx,
   input  wire logic [ser_pkg::PROD_W-1:0] in_mn,
   input  wire ser_pkg::side_type        in_side,
   output logic                          out_valid,
   output logic [ser_pkg::Q_W-1:0]       out_q,
   output ser_pkg::side_type             out_side
);
   import ser_pkg::*;

   logic [Q_W-1:0]    valid_ff;
   logic [PROD_W-1:0] rem_ff  [Q_W];
   logic [PROD_W-1:0] div_ff  [Q_W];
   logic [Q_W-1:0]    quot_ff [Q_W];
   logic              zero_ff [Q_W];
   side_type          side_ff [Q_W];

   // One quotient bit per stage, most significant first. Since mn <= mx the
   // first stage needs no shift.
   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      logic [PROD_W+1:0] rem_src;
      logic [PROD_W+1:0] trial;
      logic [PROD_W-1:0] d_src;
      logic [Q_W-1:0]    q_src;
      logic              z_src;
      logic              v_src;
      side_type          s_src;
      logic              ge;

      if (i == 0) begin : g_first
         assign rem_src = {2'b00, in_mn};
         assign d_src   = in_mx;
         assign q_src   = '0;
         assign z_src   = (in_mx == '0);
         assign v_src   = in_valid;
         assign s_src   = in_side;
      end else begin : g_next
         assign rem_src = {1'b0, rem_ff[i-1], 1'b0};
         assign d_src   = div_ff[i-1];
         assign q_src   = quot_ff[i-1];
         assign z_src   = zero_ff[i-1];
         assign v_src   = valid_ff[i-1];
         assign s_src   = side_ff[i-1];
      end

      assign trial = rem_src - {2'b00, d_src};
      assign ge    = ~trial[PROD_W+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_src;
         end
         rem_ff[i]  <= ge ? trial[PROD_W-1:0] : rem_src[PROD_W-1:0];
         div_ff[i]  <= d_src;
         quot_ff[i] <= {q_src[Q_W-2:0], ge};
         zero_ff[i] <= z_src;
         side_ff[i] <= s_src;
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_q     = zero_ff[Q_W-1] ? '0 : quot_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

`default_nettype wire

@@ hdl/ser_sqrt_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ser_sqrt_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [ser_pkg::RAD_W-1:0] in_rad,
   input  wire ser_pkg::side_type         in_side,
   output logic                           out_valid,
   output logic [ser_pkg::ROOT_W-1:0]     out_root,
   output ser_pkg::side_type              out_side
);
   import ser_pkg::*;

   logic [ROOT_W-1:0] valid_ff;
   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   side_type          side_ff [ROOT_W];

   // Bit k of the root is kept when (root + 2^k)^2 - root^2 still fits in
   // the remainder, which is the radicand minus root^2.
   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int K = ROOT_W - 1 - i;
      logic [RAD_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic              v_src;
      side_type          s_src;
      logic [RAD_W-1:0]  thr;
      logic              ge;

      if (i == 0) begin : g_first
         assign rem_src  = in_rad;
         assign root_src = '0;
         assign v_src    = in_valid;
         assign s_src    = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign v_src    = valid_ff[i-1];
         assign s_src    = side_ff[i-1];
      end

      assign thr = (RAD_W'(root_src) << (K + 1)) + (RAD_W'(1) << (2 * K));
      assign ge  = (rem_src >= thr);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_src;
         end
         rem_ff[i]  <= ge ? (rem_src - thr) : rem_src;
         root_ff[i] <= ge ? (root_src | (ROOT_W'(1) << K)) : root_src;
         side_ff[i] <= s_src;
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

@@ hdl/square_to_ellipse_pixel_remap_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Square-to-ellipse remap: maps one output pixel coordinate to the source
// pixel to fetch.
// Input: raise start with req_data holding the pixel; it is taken at any edge
// where busy is low. Busy is low at all times outside reset, so a raster
// stream may present one pixel every cycle.
// Output: rsp_strobe is high for one cycle with rsp_data; there is no
// backpressure. When use_fill is set the source lies outside the image and
// the coordinates read zero.
// Throughput is one pixel per cycle. The pipeline between the accepting edge
// and the edge that takes the result is made of the 17-stage radix-2 divider
// and the 17-stage square-root pipeline, one bit per stage each, plus three
// front stages, the squaring multiplier, the offset multipliers, the final
// add and the output register.
// Image width and height are written through csr_we/csr_index/csr_wdata and
// must change only while no pixel is in flight; values above 4096 saturate.
// Reset (synchronous) clears every valid bit in the pipeline, keeps busy high
// while asserted, and loads a 640 by 480 image size.

module square_to_ellipse_pixel_remap_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire ser_pkg::req_type         req_data,
   output logic                          rsp_strobe,
   output ser_pkg::rsp_type              rsp_data,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [ser_pkg::DIM_W-1:0] csr_wdata
);
   import ser_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff, csr_sat;

   assign csr_sat = (csr_wdata > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_sat;
            CSR_HEIGHT: height_ff <= csr_sat;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // Stage A: doubled offsets from the centre and their magnitudes.
   logic signed [OFF_W-1:0] dx2_in, dy2_in;
   logic [OFF_W-1:0]        absx_in, absy_in;
   logic                    a_valid_ff;
   side_type                a_side_ff;
   logic [DIM_W-1:0]        a_absx_ff, a_absy_ff;

   assign dx2_in  = $signed({2'b00, req_data.pixel_x, 1'b0}) - $signed({2'b00, width_ff});
   assign dy2_in  = $signed({2'b00, req_data.pixel_y, 1'b0}) - $signed({2'b00, height_ff});
   assign absx_in = dx2_in[OFF_W-1] ? OFF_W'(-dx2_in) : OFF_W'(dx2_in);
   assign absy_in = dy2_in[OFF_W-1] ? OFF_W'(-dy2_in) : OFF_W'(dy2_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start & ~busy;
      end
      a_side_ff.dx2 <= dx2_in;
      a_side_ff.dy2 <= dy2_in;
      a_absx_ff     <= absx_in[DIM_W-1:0];
      a_absy_ff     <= absy_in[DIM_W-1:0];
   end

   // Stage B: aspect scaling, both terms carry the common factor W*H.
   logic              b_valid_ff;
   side_type          b_side_ff;
   logic [PROD_W-1:0] b_a_ff, b_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_side_ff <= a_side_ff;
      b_a_ff    <= height_ff * a_absx_ff;
      b_b_ff    <= width_ff * a_absy_ff;
   end

   // Stage C: larger and smaller magnitude.
   logic              c_valid_ff;
   side_type          c_side_ff;
   logic [PROD_W-1:0] c_mx_ff, c_mn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_side_ff <= b_side_ff;
      c_mx_ff   <= (b_a_ff > b_b_ff) ? b_a_ff : b_b_ff;
      c_mn_ff   <= (b_a_ff > b_b_ff) ? b_b_ff : b_a_ff;
   end

   logic           q_valid;
   logic [Q_W-1:0] q_val;
   side_type       q_side;

   ser_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_mx     (c_mx_ff),
      .in_mn     (c_mn_ff),
      .in_side   (c_side_ff),
      .out_valid (q_valid),
      .out_q     (q_val),
      .out_side  (q_side)
   );

   // Stage D: radicand 1 + q^2 in Q4.32. At the centre q is zero, so the
   // root comes out as exactly one.
   logic [2*Q_W-1:0] sq;
   logic             d_valid_ff;
   side_type         d_side_ff;
   logic [RAD_W-1:0] d_rad_ff;

   assign sq = q_val * q_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= q_valid;
      end
      d_side_ff <= q_side;
      d_rad_ff  <= (RAD_W'(1) << (2 * FRAC_BITS)) + RAD_W'(sq);
   end

   logic              r_valid;
   logic [ROOT_W-1:0] r_val;
   side_type          r_side;

   ser_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .in_rad    (d_rad_ff),
      .in_side   (d_side_ff),
      .out_valid (r_valid),
      .out_root  (r_val),
      .out_side  (r_side)
   );

   // Stage E: ratio times doubled offset.
   logic                    e_valid_ff;
   logic signed [MUL_W-1:0] e_px_ff, e_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= r_valid;
      end
      e_px_ff <= $signed({1'b0, r_val}) * r_side.dx2;
      e_py_ff <= $signed({1'b0, r_val}) * r_side.dy2;
   end

   // Stage F: add the doubled centre in the same scale.
   logic                    f_valid_ff;
   logic signed [SUM_W-1:0] f_nx_ff, f_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_nx_ff <= $signed({{(SUM_W-DIM_W-FRAC_BITS){1'b0}}, width_ff, {FRAC_BITS{1'b0}}})
                 + SUM_W'(e_px_ff);
      f_ny_ff <= $signed({{(SUM_W-DIM_W-FRAC_BITS){1'b0}}, height_ff, {FRAC_BITS{1'b0}}})
                 + SUM_W'(e_py_ff);
   end

   // Stage G: truncate toward zero and test against the image. A negative
   // value whose magnitude truncates to zero still counts as column zero.
   logic [SUM_W-1:0]   magx, magy;
   logic [COORD_W-1:0] sx, sy;
   logic               fill_x, fill_y, fill;
   logic               out_valid_ff;
   rsp_type            out_ff;

   assign magx   = f_nx_ff[SUM_W-1] ? SUM_W'(-f_nx_ff) : SUM_W'(f_nx_ff);
   assign magy   = f_ny_ff[SUM_W-1] ? SUM_W'(-f_ny_ff) : SUM_W'(f_ny_ff);
   assign sx     = magx[SUM_W-1:FRAC_BITS+1];
   assign sy     = magy[SUM_W-1:FRAC_BITS+1];
   assign fill_x = f_nx_ff[SUM_W-1] ? (sx != '0) : (sx >= COORD_W'(width_ff));
   assign fill_y = f_ny_ff[SUM_W-1] ? (sy != '0) : (sy >= COORD_W'(height_ff));
   assign fill   = fill_x | fill_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= f_valid_ff;
      end
      out_ff.src_x    <= fill ? '0 : sx[PIX_W-1:0];
      out_ff.src_y    <= fill ? '0 : sy[PIX_W-1:0];
      out_ff.use_fill <= fill;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_ff;

endmodule

`default_nettype wire

@@ hdl/ser_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "square_to_ellipse_pixel_remap_core_macros.svh"

module ser_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic                      rsp_strobe,
   input wire ser_pkg::rsp_type          rsp_data
);
   import ser_pkg::*;

   logic zero_coords;

   assign zero_coords = (rsp_data.src_x == '0) && (rsp_data.src_y == '0);

   // Every accepted pixel gives a result.
   `SER_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##LATENCY rsp_strobe)

   // No result appears without a pixel accepted at the matching edge.
   `SER_ASSERT(a_no_spurious, clock, reset, rsp_strobe |-> $past(start && !busy, LATENCY))

   // A fill result carries zero coordinates.
   `SER_ASSERT(a_fill_zero, clock, reset, (rsp_strobe && rsp_data.use_fill) |-> zero_coords)

   // Reset empties the pipeline at once.
   `SER_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_strobe)

endmodule

bind square_to_ellipse_pixel_remap_core ser_checker u_ser_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
